>>> hdl/adrl_pkg.sv
// ============================================================================
// adrl_pkg
// Shared types and constants for the acceleration/deceleration ramp limiter.
// ============================================================================
package adrl_pkg;

    // Value format: two's complement with 8 fraction bits.
    localparam int VALUE_W   = 24;
    // Rates and the near-zero zone are unsigned, one bit narrower.
    localparam int RATE_W    = VALUE_W - 1;
    // Elapsed milliseconds saturate at 2**ELAPSED_W - 1.
    localparam int ELAPSED_W = 15;
    localparam int TIME_W    = 32;
    // A scaled step is rate times elapsed count.
    localparam int STEP_W    = RATE_W + ELAPSED_W;
    // Distance between two values needs one extra bit.
    localparam int DIST_W    = VALUE_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED = {ELAPSED_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_RATE      = 3'd0,
        REG_DECEL_RATE      = 3'd1,
        REG_NEAR_ZONE       = 3'd2,
        REG_NEAR_ACCEL_RATE = 3'd3,
        REG_NEAR_DECEL_RATE = 3'd4,
        REG_DRIVE_MODE      = 3'd5
    } cfg_reg_t;

    // Drive mode codes.
    localparam logic MODE_TIME = 1'b0;
    localparam logic MODE_CALL = 1'b1;

    // Configuration register set as seen by the datapath.
    typedef struct packed {
        logic [RATE_W-1:0] accel_rate;
        logic [RATE_W-1:0] decel_rate;
        logic [RATE_W-1:0] near_zone;
        logic [RATE_W-1:0] near_accel_rate;
        logic [RATE_W-1:0] near_decel_rate;
        logic              drive_mode;
    } cfg_t;

    // Step sizes handed from the step unit to the ramp unit.
    typedef struct packed {
        logic [STEP_W-1:0] acc_step;
        logic [STEP_W-1:0] dec_step;
        logic              time_update;
    } step_t;

    // Magnitude of a signed value, as an unsigned value of the same width.
    function automatic logic [VALUE_W-1:0] value_mag(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        r = v[VALUE_W-1] ? (~v + {{(VALUE_W-1){1'b0}}, 1'b1}) : v;
        return r;
    endfunction

endpackage

>>> hdl/adrl_cfg.sv
// ============================================================================
// adrl_cfg
// Configuration register file written through a plain write port.
// ============================================================================
module adrl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [adrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adrl_pkg::RATE_W-1:0]    cfg_data,
    output adrl_pkg::cfg_t                 cfg
);
    import adrl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes leave the set unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ACCEL_RATE:      cfg_next.accel_rate      = cfg_data;
                REG_DECEL_RATE:      cfg_next.decel_rate      = cfg_data;
                REG_NEAR_ZONE:       cfg_next.near_zone       = cfg_data;
                REG_NEAR_ACCEL_RATE: cfg_next.near_accel_rate = cfg_data;
                REG_NEAR_DECEL_RATE: cfg_next.near_decel_rate = cfg_data;
                REG_DRIVE_MODE:      cfg_next.drive_mode      = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/adrl_step.sv
// ============================================================================
// adrl_step
// Chooses the rate pair and scales it by the elapsed milliseconds.
// ============================================================================
module adrl_step (
    input  adrl_pkg::cfg_t                cfg,
    input  logic [adrl_pkg::VALUE_W-1:0]  last_output,
    input  logic [adrl_pkg::TIME_W-1:0]   last_time,
    input  logic [adrl_pkg::TIME_W-1:0]   now_ms,
    output adrl_pkg::step_t               step
);
    import adrl_pkg::*;

    logic [VALUE_W-1:0]   last_mag;
    logic                 near;
    logic [RATE_W-1:0]    acc_rate;
    logic [RATE_W-1:0]    dec_rate;
    logic [TIME_W-1:0]    elapsed_full;
    logic                 advanced;
    logic [ELAPSED_W-1:0] elapsed;
    logic [STEP_W-1:0]    acc_prod;
    logic [STEP_W-1:0]    dec_prod;

    // Near-zero zone selects the alternate rate pair.
    assign last_mag = value_mag(last_output);
    assign near     = last_mag < {1'b0, cfg.near_zone};
    assign acc_rate = near ? cfg.near_accel_rate : cfg.accel_rate;
    assign dec_rate = near ? cfg.near_decel_rate : cfg.decel_rate;

    // Elapsed time, saturated; time counts as advanced only on a strict increase.
    assign elapsed_full = now_ms - last_time;
    assign advanced     = now_ms > last_time;
    assign elapsed      = (elapsed_full > {{(TIME_W-ELAPSED_W){1'b0}}, MAX_ELAPSED})
                          ? MAX_ELAPSED : elapsed_full[ELAPSED_W-1:0];

    assign acc_prod = {{ELAPSED_W{1'b0}}, acc_rate} * {{RATE_W{1'b0}}, elapsed};
    assign dec_prod = {{ELAPSED_W{1'b0}}, dec_rate} * {{RATE_W{1'b0}}, elapsed};

    // Per-call mode uses the bare rate; a stalled clock gives a zero step.
    always_comb
    begin
        if (cfg.drive_mode == MODE_CALL)
        begin
            step.acc_step    = {{ELAPSED_W{1'b0}}, acc_rate};
            step.dec_step    = {{ELAPSED_W{1'b0}}, dec_rate};
            step.time_update = 1'b1;
        end
        else if (advanced)
        begin
            step.acc_step    = acc_prod;
            step.dec_step    = dec_prod;
            step.time_update = 1'b1;
        end
        else
        begin
            step.acc_step    = '0;
            step.dec_step    = '0;
            step.time_update = 1'b0;
        end
    end

endmodule

>>> hdl/adrl_ramp.sv
// ============================================================================
// adrl_ramp
// Moves the previous output toward the target by one limited step.
// ============================================================================
module adrl_ramp (
    input  logic [adrl_pkg::VALUE_W-1:0] target,
    input  logic [adrl_pkg::VALUE_W-1:0] last_output,
    input  adrl_pkg::step_t              step,
    output logic [adrl_pkg::VALUE_W-1:0] result
);
    import adrl_pkg::*;

    logic [DIST_W-1:0]  diff;
    logic [DIST_W-1:0]  distance;
    logic               tgt_above;
    logic [VALUE_W-1:0] tgt_mag;
    logic [VALUE_W-1:0] out_mag;
    logic               tgt_neg;
    logic               tgt_zero;
    logic               out_neg;
    logic               out_zero;
    logic               same_side;
    logic               grow;
    logic [STEP_W-1:0]  step_sel;
    logic               snap;
    logic [DIST_W-1:0]  out_ext;
    logic [DIST_W-1:0]  moved;

    // Signed distance between target and previous output.
    assign diff      = {target[VALUE_W-1], target} - {last_output[VALUE_W-1], last_output};
    assign distance  = diff[DIST_W-1] ? (~diff + {{(DIST_W-1){1'b0}}, 1'b1}) : diff;
    assign tgt_above = !diff[DIST_W-1] && (diff != '0);

    // Magnitude grows only when both lie on the same side of zero.
    assign tgt_mag   = value_mag(target);
    assign out_mag   = value_mag(last_output);
    assign tgt_neg   = target[VALUE_W-1];
    assign out_neg   = last_output[VALUE_W-1];
    assign tgt_zero  = target == '0;
    assign out_zero  = last_output == '0;
    assign same_side = (!tgt_neg && !tgt_zero && !out_neg) || (tgt_neg && (out_neg || out_zero));
    assign grow      = same_side && (tgt_mag > out_mag);

    // Snap to the target once within one step, else take one step toward it.
    assign step_sel = grow ? step.acc_step : step.dec_step;
    assign snap     = {{(STEP_W-DIST_W){1'b0}}, distance} <= step_sel;
    assign out_ext  = {last_output[VALUE_W-1], last_output};
    assign moved    = tgt_above ? (out_ext + step_sel[DIST_W-1:0])
                                : (out_ext - step_sel[DIST_W-1:0]);
    assign result   = snap ? target : moved[VALUE_W-1:0];

endmodule

>>> hdl/accel_decel_ramp_limiter_unit.sv
// ============================================================================
// accel_decel_ramp_limiter_unit
// Asymmetric slew-rate limiter with near-zero rates and time scaling.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries now_ms and target; each
//   transaction yields exactly one output transaction (out_valid/out_stall)
//   carrying smoothed. Configuration registers are written through
//   cfg_wr_en/cfg_index/cfg_data while no transaction is in flight.
//   A transaction accepted is captured in the input register, and its
//   result is loaded into the output register once that register is free,
//   which raises out_valid.
//   One transaction per cycle while the receiver does not stall. Step
//   selection, the rate-by-elapsed-time multiply and the ramp compare-select
//   are combinational between the input and output registers, and the stored
//   output and timestamp are updated in the same cycle as the output register.
//   When the receiver stalls, the result stays in the output register and
//   the input register may still hold one more transaction; in_stall rises
//   only when both are full.
//   Reset clears the configuration, the stored output and the stored
//   timestamp to zero, and empties both registers.
// ============================================================================
module accel_decel_ramp_limiter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [adrl_pkg::TIME_W-1:0]    now_ms,
    input  logic signed [adrl_pkg::VALUE_W-1:0] target,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [adrl_pkg::VALUE_W-1:0] smoothed,
    input  logic                           cfg_wr_en,
    input  logic [adrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adrl_pkg::RATE_W-1:0]    cfg_data
);
    import adrl_pkg::*;

    cfg_t               cfg;
    step_t              step;
    logic [VALUE_W-1:0] ramp_result;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [TIME_W-1:0]  now_reg;
    logic [VALUE_W-1:0] target_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] smoothed_reg;
    logic [VALUE_W-1:0] last_output_reg;
    logic [VALUE_W-1:0] last_output_next;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  last_time_next;

    logic               out_free;
    logic               advance;
    logic               in_take;

    adrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adrl_step u_step (
        .cfg         (cfg),
        .last_output (last_output_reg),
        .last_time   (last_time_reg),
        .now_ms      (now_reg),
        .step        (step)
    );

    adrl_ramp u_ramp (
        .target      (target_reg),
        .last_output (last_output_reg),
        .step        (step),
        .result      (ramp_result)
    );

    // Handshake: the output register frees up when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Next-state logic for the pipeline and the ramp state.
    always_comb
    begin
        in_valid_next    = in_take || (in_valid_reg && !advance);
        out_valid_next   = advance || (out_valid_reg && out_stall);
        last_output_next = advance ? ramp_result : last_output_reg;
        last_time_next   = (advance && step.time_update) ? now_reg : last_time_reg;
    end

    // Control and ramp state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_output_reg <= '0;
            last_time_reg   <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            last_output_reg <= last_output_next;
            last_time_reg   <= last_time_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg    <= now_ms;
            target_reg <= target;
        end
        if (advance)
        begin
            smoothed_reg <= ramp_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign smoothed  = smoothed_reg;

endmodule
